// ----- rtl/itws_pkg.sv -----
// ----------------------------------------------------------------------------
// itws_pkg
// Shared types and constants of the interval timer with window statistics.
// ----------------------------------------------------------------------------
package itws_pkg;

  localparam int TIME_BITS  = 48;
  localparam int WINDOW_DEF = 64;
  localparam int Q_W        = 17;
  localparam int CFG_W      = 7;
  localparam int FILL_OUT_W = 7;
  localparam int TOTAL_W    = 32;

  localparam logic [Q_W-1:0] Q_ONE  = 17'd65536;
  localparam logic [Q_W-1:0] Q_HALF = 17'd32768;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_LAP   = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSTART = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADP    = 2'd3;

  localparam logic REG_STATS_EN  = 1'b0;
  localparam logic REG_WIN_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] WIN_LIMIT_RST = 7'd64;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [TIME_BITS-1:0] timestamp;
    logic [Q_W-1:0]       percentile_q;
  } itws_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  running_now;
    logic [TIME_BITS-1:0]  elapsed_ns;
    logic [TIME_BITS-1:0]  min_ns;
    logic [TIME_BITS-1:0]  max_ns;
    logic [TIME_BITS-1:0]  mean_ns;
    logic [TIME_BITS-1:0]  median_ns;
    logic [TIME_BITS-1:0]  percentile_ns;
    logic [FILL_OUT_W-1:0] samples_held;
    logic [TOTAL_W-1:0]    measurements_total;
  } itws_out_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/itws_cell.sv -----
// ----------------------------------------------------------------------------
// itws_cell
// One cell of the sorting row: keeps the smaller value, passes the larger on,
// and shifts toward the head of the row while the sorted set is read out.
// ----------------------------------------------------------------------------
module itws_cell import itws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [TIME_BITS-1:0] in_val,
  input  logic                 in_vld,
  input  logic [TIME_BITS-1:0] right_val,
  output logic [TIME_BITS-1:0] hold_val,
  output logic [TIME_BITS-1:0] pass_val,
  output logic                 pass_vld
);

  logic hold_vld;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hold_vld <= 1'b0;
      pass_vld <= 1'b0;
    end else if (ctl.shift) begin
      hold_val <= right_val;
      pass_vld <= 1'b0;
    end else if (in_vld) begin
      if (!hold_vld) begin
        hold_val <= in_val;
        hold_vld <= 1'b1;
        pass_vld <= 1'b0;
      end else if (in_val < hold_val) begin
        hold_val <= in_val;
        pass_val <= hold_val;
        pass_vld <= 1'b1;
      end else begin
        pass_val <= in_val;
        pass_vld <= 1'b1;
      end
    end else begin
      pass_vld <= 1'b0;
    end
  end

endmodule

// ----- rtl/itws_div.sv -----
// ----------------------------------------------------------------------------
// itws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itws_div import itws_pkg::*; #(
  parameter int DW = 54,
  parameter int NW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;
  logic [NW:0]   rem_sh;

  assign rem_sh = {rem, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      cnt      <= '0;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem      <= NW'(rem_sh - {1'b0, dsr});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[NW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/interval_timer_window_statistics_top.sv -----
// ----------------------------------------------------------------------------
// interval_timer_window_statistics_top
// Interval timer keeping a sliding window of measured durations, with
// min, max, mean and interpolated median and percentile on query.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command per transfer;
//   out channel (out_valid/out_ready/out_data) gives one result per command.
//   cfg_we/cfg_index/cfg_data write stats_enable (0) and window_limit (1),
//   which the user must do while the block is idle; the block does not check.
// Steps: start, reset, clear samples and unknown commands pass through the
//   execute and finish states; stop and lap add an evict state between them
//   when a sample is evicted (one read of the sample memory first).
//   A query streams the samples from the memory into the row of sorting
//   cells one per cycle, lets them settle, and shifts them out one per
//   cycle; the mean divider runs alongside.
// Throughput: one command at a time; in_ready is high when idle.
// Reset: synchronous; timer stopped, counts and window empty, stats
//   disabled, window_limit 64.
// Stall: a result waits in the output register while out_ready is low;
//   the next command is taken meanwhile and holds in its last step.
// ----------------------------------------------------------------------------
module interval_timer_window_statistics_top import itws_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  itws_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output itws_out_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SW      = $clog2(WINDOW);
  localparam int NW      = $clog2(WINDOW + 1);
  localparam int SUM_RAW = TIME_BITS + $clog2(WINDOW);
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int LW      = (NW > CFG_W) ? NW : CFG_W;
  localparam int IDXW    = Q_W + NW;
  localparam int LOW_W   = IDXW - 16;
  localparam int STW     = $clog2(WINDOW + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_EVICT  = 4'd2;
  localparam logic [3:0] S_FEED   = 4'd3;
  localparam logic [3:0] S_SETTLE = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_DIFF   = 4'd6;
  localparam logic [3:0] S_MULT   = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]           state;
  itws_in_t             cur;
  logic [TIME_BITS-1:0] start_stamp;
  logic                 running;
  logic [TIME_BITS-1:0] last_el;
  logic [TOTAL_W-1:0]   total;
  logic [NW-1:0]        fill;
  logic [SW-1:0]        oldest;
  logic [SUM_W-1:0]     sum;
  logic                 stats_en;
  logic [CFG_W-1:0]     win_limit;

  logic [1:0]           r_status;
  logic [TIME_BITS-1:0] r_el, r_min, r_max, r_mean, r_med, r_pct;
  logic [TIME_BITS-1:0] pend_el;

  logic [LOW_W-1:0]     lo_m, lo_p;
  logic [15:0]          f_m, f_p;
  logic                 bad_p;
  logic [SW-1:0]        rd_ptr;
  logic [NW-1:0]        feed_cnt;
  logic [STW-1:0]       settle_cnt;
  logic [NW-1:0]        k;
  logic [TIME_BITS-1:0] slo_m, shi_m, slo_p, shi_p, diff_m, diff_p;
  logic [TIME_BITS-1:0] ph_m, ph_p;
  logic [31:0]          pl_m, pl_p;
  logic                 feed_vld;

  logic [TIME_BITS-1:0] mem [WINDOW];
  logic                 mem_we;
  logic [SW-1:0]        mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [SW-1:0]        mem_raddr;
  logic [TIME_BITS-1:0] mem_rdata;

  logic [TIME_BITS-1:0] el_meas;
  logic                 is_meas;
  logic [LW-1:0]        lim;
  logic                 evict_need;
  logic [NW:0]          ws;
  logic [SW-1:0]        wr_slot;
  logic [SW-1:0]        rd_ptr_next;
  logic                 q_start;
  logic [IDXW-1:0]      idx_m, idx_p;
  logic [NW-1:0]        n_m1;
  logic                 m_top, p_top;
  logic                 out_load;

  logic                 div_done;
  logic [SUM_W-1:0]     quotient;

  cell_ctl_t            ctl;
  logic [TIME_BITS-1:0] c_in_val   [WINDOW];
  logic                 c_in_vld   [WINDOW];
  logic [TIME_BITS-1:0] c_right    [WINDOW];
  logic [TIME_BITS-1:0] c_hold     [WINDOW];
  logic [TIME_BITS-1:0] c_pass_val [WINDOW];
  logic                 c_pass_vld [WINDOW];

  // combinational decode
  assign in_ready = (state == S_IDLE);
  assign el_meas  = cur.timestamp - start_stamp;
  assign is_meas  = ((cur.cmd == CMD_STOP) || (cur.cmd == CMD_LAP)) && running;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    if (win_limit == '0) begin
      lim = LW'(1);
    end else if (LW'(win_limit) > LW'(WINDOW)) begin
      lim = LW'(WINDOW);
    end else begin
      lim = LW'(win_limit);
    end
  end

  assign evict_need = (LW'(fill) >= lim) && (fill != '0);

  always_comb begin
    ws = (NW + 1)'(oldest) + (NW + 1)'(fill);
    if (ws >= (NW + 1)'(WINDOW)) begin
      ws = ws - (NW + 1)'(WINDOW);
    end
    wr_slot = ws[SW-1:0];
  end

  assign rd_ptr_next = (rd_ptr == SW'(WINDOW - 1)) ? '0 : rd_ptr + 1'b1;

  assign q_start = (state == S_EXEC) && (cur.cmd == CMD_QUERY) &&
                   (running || (total != '0)) && (fill != '0);

  assign n_m1  = fill - 1'b1;
  assign idx_m = IDXW'(Q_HALF) * IDXW'(n_m1);
  assign idx_p = IDXW'(cur.percentile_q) * IDXW'(n_m1);
  assign m_top = (lo_m + 1'b1) >= LOW_W'(fill);
  assign p_top = (lo_p + 1'b1) >= LOW_W'(fill);

  // sample memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = el_meas;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr;
    if (state == S_EXEC && is_meas && stats_en) begin
      if (evict_need) begin
        mem_re    = 1'b1;
        mem_raddr = oldest;
      end else begin
        mem_we = 1'b1;
      end
    end else if (state == S_EVICT) begin
      mem_we    = 1'b1;
      mem_wdata = pend_el;
    end else if (state == S_FEED) begin
      mem_re = 1'b1;
    end
  end

  assign mem_waddr = wr_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // sorting row
  assign ctl.clear = q_start;
  assign ctl.shift = (state == S_SHIFT);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign c_in_val[i] = mem_rdata;
      assign c_in_vld[i] = feed_vld;
    end else begin : g_body
      assign c_in_val[i] = c_pass_val[i-1];
      assign c_in_vld[i] = c_pass_vld[i-1];
    end
    if (i == WINDOW - 1) begin : g_tail
      assign c_right[i] = '0;
    end else begin : g_mid
      assign c_right[i] = c_hold[i+1];
    end

    itws_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .in_val    (c_in_val[i]),
      .in_vld    (c_in_vld[i]),
      .right_val (c_right[i]),
      .hold_val  (c_hold[i]),
      .pass_val  (c_pass_val[i]),
      .pass_vld  (c_pass_vld[i])
    );
  end

  itws_div #(
    .DW (SUM_W),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (q_start),
    .dividend (sum),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quotient)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_stamp <= '0;
      running     <= 1'b0;
      last_el     <= '0;
      total       <= '0;
      fill        <= '0;
      oldest      <= '0;
      sum         <= '0;
      stats_en    <= 1'b0;
      win_limit   <= WIN_LIMIT_RST;
      out_valid   <= 1'b0;
      feed_vld    <= 1'b0;
    end else begin
      feed_vld <= (state == S_FEED);

      if (cfg_we) begin
        case (cfg_index)
          REG_STATS_EN:  stats_en  <= cfg_data[0];
          REG_WIN_LIMIT: win_limit <= cfg_data;
          default:       ;
        endcase
      end

      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= in_data;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          r_status <= ST_OK;
          r_el     <= '0;
          r_min    <= '0;
          r_max    <= '0;
          r_mean   <= '0;
          r_med    <= '0;
          r_pct    <= '0;
          state    <= S_FIN;
          case (cur.cmd)
            CMD_START: begin
              start_stamp <= cur.timestamp;
              running     <= 1'b1;
            end
            CMD_STOP, CMD_LAP: begin
              if (!running) begin
                r_status <= ST_NOSTART;
              end else begin
                r_el    <= el_meas;
                last_el <= el_meas;
                total   <= total + 1'b1;
                if (cur.cmd == CMD_STOP) begin
                  running <= 1'b0;
                end else begin
                  start_stamp <= cur.timestamp;
                end
                if (stats_en) begin
                  if (evict_need) begin
                    pend_el <= el_meas;
                    state   <= S_EVICT;
                  end else begin
                    fill <= fill + 1'b1;
                    sum  <= sum + SUM_W'(el_meas);
                  end
                end
              end
            end
            CMD_RESET: begin
              running <= 1'b0;
              total   <= '0;
              last_el <= '0;
              fill    <= '0;
              oldest  <= '0;
              sum     <= '0;
            end
            CMD_CLEAR: begin
              fill   <= '0;
              oldest <= '0;
              sum    <= '0;
            end
            CMD_QUERY: begin
              if (!running && total == '0) begin
                r_status <= ST_NOSTART;
              end else begin
                r_el <= running ? el_meas : last_el;
                if (fill == '0) begin
                  r_status <= ST_EMPTY;
                end else begin
                  lo_m     <= idx_m[IDXW-1:16];
                  f_m      <= idx_m[15:0];
                  lo_p     <= idx_p[IDXW-1:16];
                  f_p      <= idx_p[15:0];
                  bad_p    <= (cur.percentile_q > Q_ONE);
                  rd_ptr   <= oldest;
                  feed_cnt <= '0;
                  state    <= S_FEED;
                end
              end
            end
            default: ;
          endcase
        end

        S_EVICT: begin
          sum    <= sum - SUM_W'(mem_rdata) + SUM_W'(pend_el);
          oldest <= (oldest == SW'(WINDOW - 1)) ? '0 : oldest + 1'b1;
          state  <= S_FIN;
        end

        S_FEED: begin
          rd_ptr   <= rd_ptr_next;
          feed_cnt <= feed_cnt + 1'b1;
          if (feed_cnt == n_m1) begin
            settle_cnt <= '0;
            state      <= S_SETTLE;
          end
        end

        S_SETTLE: begin
          settle_cnt <= settle_cnt + 1'b1;
          if (settle_cnt == STW'(WINDOW)) begin
            k     <= '0;
            state <= S_SHIFT;
          end
        end

        S_SHIFT: begin
          if (k == '0) begin
            r_min <= c_hold[0];
          end
          if (LOW_W'(k) == lo_m) begin
            slo_m <= c_hold[0];
          end
          if (LOW_W'(k) == lo_m + 1'b1) begin
            shi_m <= c_hold[0];
          end
          if (LOW_W'(k) == lo_p) begin
            slo_p <= c_hold[0];
          end
          if (LOW_W'(k) == lo_p + 1'b1) begin
            shi_p <= c_hold[0];
          end
          k <= k + 1'b1;
          if (k == n_m1) begin
            r_max <= c_hold[0];
            state <= S_DIFF;
          end
        end

        S_DIFF: begin
          if (div_done) begin
            diff_m <= shi_m - slo_m;
            diff_p <= shi_p - slo_p;
            r_mean <= quotient[TIME_BITS-1:0];
            state  <= S_MULT;
          end
        end

        S_MULT: begin
          ph_m  <= TIME_BITS'(diff_m[TIME_BITS-1:16]) * TIME_BITS'(f_m);
          pl_m  <= diff_m[15:0] * f_m;
          ph_p  <= TIME_BITS'(diff_p[TIME_BITS-1:16]) * TIME_BITS'(f_p);
          pl_p  <= diff_p[15:0] * f_p;
          state <= S_SUM;
        end

        S_SUM: begin
          r_med <= m_top ? r_max : slo_m + ph_m + TIME_BITS'(pl_m[31:16]);
          if (bad_p) begin
            r_status <= ST_BADP;
            r_pct    <= '0;
          end else begin
            r_pct <= p_top ? r_max : slo_p + ph_p + TIME_BITS'(pl_p[31:16]);
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (out_load) begin
            out_data.status             <= r_status;
            out_data.running_now        <= running;
            out_data.elapsed_ns         <= r_el;
            out_data.min_ns             <= r_min;
            out_data.max_ns             <= r_max;
            out_data.mean_ns            <= r_mean;
            out_data.median_ns          <= r_med;
            out_data.percentile_ns      <= r_pct;
            out_data.samples_held       <= FILL_OUT_W'(fill);
            out_data.measurements_total <= total;
            out_valid                   <= 1'b1;
            state                       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (NW + 1)'(fill) <= (NW + 1)'(WINDOW))
    else $error("window fill above capacity");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (sum == '0))
    else $error("empty window with nonzero sum");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while busy");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (k < fill))
    else $error("readout index past window fill");
`endif

endmodule
